// ===== rtl/core/ibcm_pkg.sv =====
`default_nettype none

package ibcm_pkg;

    // Field and datapath widths
    localparam int AXES        = 6;
    localparam int SUM_W       = 24;
    localparam int ACC_W       = 26;
    localparam int CORR_W      = 17;
    localparam int SQ_W        = 34;
    localparam int ROOT_W      = 17;
    localparam int DPS_W       = 16;
    localparam int CNT_W       = 8;
    localparam int GRAV_W      = 14;
    localparam int SCALE_W     = 15;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 14;
    localparam int OUT_TDATA_W = 136;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CALIB_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY     = 1'd1;

    // Register reset values and fixed constants
    localparam logic [CNT_W-1:0]   CALIB_COUNT_RST = 8'd100;
    localparam logic [GRAV_W-1:0]  GRAVITY_RST     = 14'd2509;
    localparam logic [SCALE_W-1:0] DPS_SCALE       = 15'd29334;

    localparam logic signed [CORR_W-1:0] CORR_MAX = 17'h0FFFF;
    localparam logic signed [CORR_W-1:0] CORR_MIN = 17'h10000;

    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [CORR_W-1:0] corr_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [ROOT_W-1:0]        root_t;

    // Saturate a widened sum back to the signed sum range
    function automatic sum_t sat_sum(input logic signed [ACC_W-1:0] v);
        sum_t r;
        if (v[ACC_W-1:SUM_W-1] == '0 || v[ACC_W-1:SUM_W-1] == '1)
            r = v[SUM_W-1:0];
        else if (v[ACC_W-1])
            r = {1'b1, {(SUM_W-1){1'b0}}};
        else
            r = {1'b0, {(SUM_W-1){1'b1}}};
        return r;
    endfunction

    // Magnitude of a corrected value; -65536 maps to 65536
    function automatic root_t corr_mag(input corr_t v);
        root_t r;
        if (v[CORR_W-1])
            r = ROOT_W'(-v);
        else
            r = ROOT_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ibcm_div.sv =====
`default_nettype none

// Serial restoring divider: signed sum over unsigned count, truncated
// toward zero, one quotient bit per cycle, result saturated to 17 bits.
module ibcm_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  ibcm_pkg::sum_t               dividend,
    input  logic [ibcm_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output ibcm_pkg::corr_t              quotient
);

    localparam int ITER_W = $clog2(ibcm_pkg::SUM_W);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ibcm_pkg::SUM_W - 1);

    logic                           busy_reg;
    logic                           done_reg;
    logic [ITER_W-1:0]              cnt_reg;
    logic [ibcm_pkg::CNT_W-1:0]     rem_reg;
    logic [ibcm_pkg::SUM_W-1:0]     quo_reg;
    logic [ibcm_pkg::CNT_W-1:0]     dsr_reg;
    logic                           neg_reg;

    logic [ibcm_pkg::CNT_W:0]       shifted;
    logic [ibcm_pkg::CNT_W:0]       diff;
    logic                           ge;
    logic [ibcm_pkg::SUM_W-1:0]     neg_q;

    // One restoring step
    assign shifted = {rem_reg, quo_reg[ibcm_pkg::SUM_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = shifted >= {1'b0, dsr_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[ibcm_pkg::SUM_W-1];
            quo_reg <= dividend[ibcm_pkg::SUM_W-1] ? ibcm_pkg::SUM_W'(-dividend)
                                                   : ibcm_pkg::SUM_W'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[ibcm_pkg::CNT_W-1:0] : shifted[ibcm_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[ibcm_pkg::SUM_W-2:0], ge};
        end
    end

    // Restore sign and saturate
    assign neg_q = -quo_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > ibcm_pkg::SUM_W'(65536))
                quotient = ibcm_pkg::CORR_MIN;
            else
                quotient = neg_q[ibcm_pkg::CORR_W-1:0];
        end
        else
        begin
            if (quo_reg > ibcm_pkg::SUM_W'(65535))
                quotient = ibcm_pkg::CORR_MAX;
            else
                quotient = quo_reg[ibcm_pkg::CORR_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ibcm_sqsum.sv =====
`default_nettype none

// Bit-serial sum of three squares: all three multipliers shift out
// MSB first in lockstep into one shared accumulator.
module ibcm_sqsum
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ibcm_pkg::corr_t   in_a,
    input  ibcm_pkg::corr_t   in_b,
    input  ibcm_pkg::corr_t   in_c,
    output logic              done,
    output ibcm_pkg::sq_t     sum
);

    localparam int ITER_W = $clog2(ibcm_pkg::ROOT_W);
    localparam int TERM_W = ibcm_pkg::ROOT_W + 2;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ibcm_pkg::ROOT_W - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [ITER_W-1:0]      cnt_reg;
    ibcm_pkg::root_t        mcand_reg [3];
    ibcm_pkg::root_t        mlier_reg [3];
    ibcm_pkg::sq_t          acc_reg;

    logic [TERM_W-1:0]      term;

    // Partial products selected by the current multiplier bits
    always_comb
    begin
        term = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (mlier_reg[i][ibcm_pkg::ROOT_W-1])
                term = term + TERM_W'(mcand_reg[i]);
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift multipliers left, double and add into the accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg[0] <= ibcm_pkg::corr_mag(in_a);
            mcand_reg[1] <= ibcm_pkg::corr_mag(in_b);
            mcand_reg[2] <= ibcm_pkg::corr_mag(in_c);
            mlier_reg[0] <= ibcm_pkg::corr_mag(in_a);
            mlier_reg[1] <= ibcm_pkg::corr_mag(in_b);
            mlier_reg[2] <= ibcm_pkg::corr_mag(in_c);
            acc_reg      <= '0;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
                mlier_reg[i] <= {mlier_reg[i][ibcm_pkg::ROOT_W-2:0], 1'b0};
            acc_reg <= {acc_reg[ibcm_pkg::SQ_W-2:0], 1'b0} + ibcm_pkg::SQ_W'(term);
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ibcm_sqrt.sv =====
`default_nettype none

// Digit-by-digit floor square root: two radicand bits in, one root bit
// out per cycle.
module ibcm_sqrt
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ibcm_pkg::sq_t     radicand,
    output logic              done,
    output ibcm_pkg::root_t   root
);

    localparam int ITER_W = $clog2(ibcm_pkg::ROOT_W);
    localparam int REM_W  = ibcm_pkg::ROOT_W + 2;
    localparam int SH_W   = REM_W + 2;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ibcm_pkg::ROOT_W - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [ITER_W-1:0]      cnt_reg;
    ibcm_pkg::sq_t          rad_reg;
    logic [REM_W-1:0]       rem_reg;
    ibcm_pkg::root_t        root_reg;

    logic [SH_W-1:0]        shifted;
    logic [SH_W-1:0]        trial;
    logic [SH_W-1:0]        diff;
    logic                   ge;

    // One root digit
    assign shifted = {rem_reg, rad_reg[ibcm_pkg::SQ_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign diff    = shifted - trial;
    assign ge      = shifted >= trial;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, root and radicand shift registers; root holds when idle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[ibcm_pkg::SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_reg <= {root_reg[ibcm_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/core/imu_bias_calibrate_and_magnitude.sv =====
`default_nettype none

// IMU bias calibration and vector magnitudes. After reset the first
// calib_count sample beats (zero counts as one) are summed per axis, with
// gravity_value taken off Z, at one beat per cycle and with no output beat.
// The last of them starts a serial divider that forms the six offsets at one
// quotient bit per cycle; while it runs no sample is taken. Every later
// sample gives one output beat: the six axes minus their offsets, saturated
// to 17 bits, the floor square root of the accel squares sum, and the gyro
// magnitude in 1/16 deg/s. Each such sample passes through the bit-serial
// squaring followed by the digit-serial square root, which the accel and
// gyro lanes run side by side, and no new sample is taken until it is done.
// A finished result waits in the output register, so the next sample is
// taken while it is still pending. Configuration writes take effect at
// once; after calibration they change nothing until reset.
module imu_bias_calibrate_and_magnitude
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, zero fill
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((ibcm_pkg::AXES*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,

    // corr_accel_x/y/z, corr_gyro_x/y/z, accel_magnitude,
    // gyro_magnitude_dps, zero fill
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ibcm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,

    input  logic                                  cfg_wr_en,
    input  logic [ibcm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ibcm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int DIFF_W = ((SAMPLE_WIDTH > ibcm_pkg::CORR_W) ? SAMPLE_WIDTH
                                                               : ibcm_pkg::CORR_W) + 1;
    localparam int AXIS_W = $clog2(ibcm_pkg::AXES);
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(ibcm_pkg::AXES - 1);
    localparam int PROD_W = ibcm_pkg::ROOT_W + ibcm_pkg::SCALE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MAG  = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;

    logic [ibcm_pkg::CNT_W-1:0]       calib_count_reg;
    logic [ibcm_pkg::GRAV_W-1:0]      gravity_reg;
    logic [ibcm_pkg::CNT_W-1:0]       sample_count_reg;
    logic                             calibrated_reg;
    ibcm_pkg::sum_t                   sums_reg    [ibcm_pkg::AXES];
    ibcm_pkg::corr_t                  offsets_reg [ibcm_pkg::AXES];
    logic [ibcm_pkg::CNT_W-1:0]       taken_reg;
    logic [AXIS_W-1:0]                axis_reg;
    logic                             div_start_reg;
    logic                             sq_start_reg;
    ibcm_pkg::corr_t                  corr_reg    [ibcm_pkg::AXES];
    logic                             out_valid_reg;
    logic [ibcm_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic signed [SAMPLE_WIDTH-1:0]   samp     [ibcm_pkg::AXES];
    ibcm_pkg::sum_t                   sum_new  [ibcm_pkg::AXES];
    ibcm_pkg::corr_t                  corr_new [ibcm_pkg::AXES];
    logic [ibcm_pkg::CNT_W-1:0]       target;
    logic [ibcm_pkg::CNT_W-1:0]       taken;
    logic                             calib_last;
    logic                             in_beat;
    logic                             out_load;

    logic                             div_done;
    ibcm_pkg::corr_t                  div_quot;
    logic                             acc_sq_done;
    logic                             gyr_sq_done;
    ibcm_pkg::sq_t                    acc_sq;
    ibcm_pkg::sq_t                    gyr_sq;
    logic                             acc_rt_done;
    logic                             gyr_rt_done;
    ibcm_pkg::root_t                  acc_root;
    ibcm_pkg::root_t                  gyr_root;
    logic [PROD_W-1:0]                dps_prod;

    // Unpack the sample and form sums and corrected values per axis
    for (genvar i = 0; i < ibcm_pkg::AXES; i++)
    begin : g_axis
        logic signed [ibcm_pkg::ACC_W-1:0] add;
        logic signed [DIFF_W-1:0]          diff;

        assign samp[i] = s_axis_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];

        always_comb
        begin
            add = ibcm_pkg::ACC_W'(samp[i]);
            if (i == 2)
                add = add - ibcm_pkg::ACC_W'(gravity_reg);
            sum_new[i] = ibcm_pkg::sat_sum(ibcm_pkg::ACC_W'(sums_reg[i]) + add);
        end

        assign diff = DIFF_W'(samp[i]) - DIFF_W'(offsets_reg[i]);

        always_comb
        begin
            if (diff > DIFF_W'(ibcm_pkg::CORR_MAX))
                corr_new[i] = ibcm_pkg::CORR_MAX;
            else if (diff < DIFF_W'(ibcm_pkg::CORR_MIN))
                corr_new[i] = ibcm_pkg::CORR_MIN;
            else
                corr_new[i] = diff[ibcm_pkg::CORR_W-1:0];
        end
    end

    // Calibration progress
    assign target     = (calib_count_reg == '0) ? ibcm_pkg::CNT_W'(1) : calib_count_reg;
    assign taken      = sample_count_reg + 1'b1;
    assign calib_last = taken >= target;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_LOAD) && (!out_valid_reg || m_axis_tready);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_count_reg <= ibcm_pkg::CALIB_COUNT_RST;
            gravity_reg     <= ibcm_pkg::GRAVITY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                ibcm_pkg::REG_CALIB_COUNT: calib_count_reg <= cfg_wdata[ibcm_pkg::CNT_W-1:0];
                ibcm_pkg::REG_GRAVITY:     gravity_reg     <= cfg_wdata;
                default:                   gravity_reg     <= gravity_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (calibrated_reg)
                        state_next = ST_MAG;
                    else if (calib_last)
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done && axis_reg == LAST_AXIS)
                    state_next = ST_IDLE;
            end
            ST_MAG:
            begin
                if (acc_rt_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, sums and offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_count_reg <= '0;
            calibrated_reg   <= 1'b0;
            axis_reg         <= '0;
            div_start_reg    <= 1'b0;
            sq_start_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < ibcm_pkg::AXES; i++)
            begin
                sums_reg[i]    <= '0;
                offsets_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;

            // Accumulate a calibration beat, or start the magnitude lanes
            if (in_beat)
            begin
                if (!calibrated_reg)
                begin
                    for (int i = 0; i < ibcm_pkg::AXES; i++)
                        sums_reg[i] <= sum_new[i];
                    sample_count_reg <= taken;
                    if (calib_last)
                    begin
                        axis_reg      <= '0;
                        div_start_reg <= 1'b1;
                    end
                end
                else
                begin
                    sq_start_reg <= 1'b1;
                end
            end

            // Store each offset and advance to the next axis
            if (state_reg == ST_DIV && div_done)
            begin
                offsets_reg[axis_reg] <= div_quot;
                if (axis_reg == LAST_AXIS)
                begin
                    calibrated_reg <= 1'b1;
                end
                else
                begin
                    axis_reg      <= axis_reg + 1'b1;
                    div_start_reg <= 1'b1;
                end
            end

            // Output beat valid until taken
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat && !calibrated_reg && calib_last)
            taken_reg <= taken;
        if (in_beat && calibrated_reg)
        begin
            for (int i = 0; i < ibcm_pkg::AXES; i++)
                corr_reg[i] <= corr_new[i];
        end
        if (out_load)
            out_data_reg <= {1'b0, dps_prod[PROD_W-1 -: ibcm_pkg::DPS_W], acc_root,
                             corr_reg[5], corr_reg[4], corr_reg[3],
                             corr_reg[2], corr_reg[1], corr_reg[0]};
    end

    // Gyro magnitude scaling to 1/16 deg/s
    assign dps_prod = PROD_W'(gyr_root) * PROD_W'(ibcm_pkg::DPS_SCALE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    ibcm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sums_reg[axis_reg]),
        .divisor  (taken_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    ibcm_sqsum u_acc_sqsum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .in_a  (corr_reg[0]),
        .in_b  (corr_reg[1]),
        .in_c  (corr_reg[2]),
        .done  (acc_sq_done),
        .sum   (acc_sq)
    );

    ibcm_sqsum u_gyr_sqsum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .in_a  (corr_reg[3]),
        .in_b  (corr_reg[4]),
        .in_c  (corr_reg[5]),
        .done  (gyr_sq_done),
        .sum   (gyr_sq)
    );

    ibcm_sqrt u_acc_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_sq_done),
        .radicand (acc_sq),
        .done     (acc_rt_done),
        .root     (acc_root)
    );

    ibcm_sqrt u_gyr_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (gyr_sq_done),
        .radicand (gyr_sq),
        .done     (gyr_rt_done),
        .root     (gyr_root)
    );

`ifndef NO_ASSERTIONS
    a_calibrated_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        calibrated_reg |=> calibrated_reg)
        else $error("calibrated flag dropped");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside offset phase");

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_rt_done == gyr_rt_done) && (acc_sq_done == gyr_sq_done))
        else $error("accel and gyro lanes out of step");

    a_result_after_calib: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> calibrated_reg)
        else $error("result beat before calibration finished");
`endif

endmodule

`default_nettype wire
